/* hdl/hsb_pkg.sv */
// shared types and constants for the hsb to rgb colour converter
// no dependencies; imported by every module of the block
package hsb_pkg;

   localparam int HUE_W    = 24;
   localparam int LEVEL_W  = 17;
   localparam int CHAN_W   = 8;
   localparam int SECTOR_W = 3;

   typedef enum logic [SECTOR_W-1:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic signed [HUE_W-1:0] hue_turns;
      logic [LEVEL_W-1:0]      saturation_level;
      logic [LEVEL_W-1:0]      brightness_level;
   } hsb_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } hsb_rsp_type;

endpackage

/* hdl/hsb_front.sv */
// first stage: hue fraction times six, saturation and brightness clamped to one
// depends on hsb_pkg
module hsb_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsb_pkg::hsb_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsb_pkg::sector_type  sector,
   output logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   one_minus_frac,
   output logic [FRAC_BITS:0]   sat,
   output logic [FRAC_BITS:0]   bri
);
   import hsb_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int CMP_W = (F + 1 > LEVEL_W) ? F + 1 : LEVEL_W;
   localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << F;
   localparam logic [F:0]       ONE     = (F+1)'(1) << F;

   logic             valid_ff, valid_in;
   sector_type       sector_ff, sector_in;
   logic [F-1:0]     frac_ff, frac_in;
   logic [F:0]       omf_ff, omf_in;
   logic [F:0]       sat_ff, sat_in;
   logic [F:0]       bri_ff, bri_in;
   logic [F-1:0]     hue;
   logic [F+2:0]     h6;
   logic [CMP_W-1:0] sat_ext, bri_ext;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // low bits of a two's complement hue are already hue minus its floor
      hue     = in_data.hue_turns[F-1:0];
      h6      = (F+3)'(hue) * (F+3)'(3'd6);
      sat_ext = CMP_W'(in_data.saturation_level);
      bri_ext = CMP_W'(in_data.brightness_level);
      sat_in    = (sat_ext > ONE_CMP) ? ONE : sat_ext[F:0];
      bri_in    = (bri_ext > ONE_CMP) ? ONE : bri_ext[F:0];
      sector_in = sector_type'(h6[F+2:F]);
      frac_in   = h6[F-1:0];
      omf_in    = ONE - (F+1)'(h6[F-1:0]);
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
         omf_ff    <= omf_in;
         sat_ff    <= sat_in;
         bri_ff    <= bri_in;
      end
   end

   assign out_valid      = valid_ff;
   assign sector         = sector_ff;
   assign frac           = frac_ff;
   assign one_minus_frac = omf_ff;
   assign sat            = sat_ff;
   assign bri            = bri_ff;

endmodule

/* hdl/hsb_mul.sv */
// second and third stages: s*f and s*(1-f), then p, q and t from the brightness
// depends on hsb_pkg
module hsb_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsb_pkg::sector_type  in_sector,
   input  logic [FRAC_BITS-1:0] frac,
   input  logic [FRAC_BITS:0]   one_minus_frac,
   input  logic [FRAC_BITS:0]   sat,
   input  logic [FRAC_BITS:0]   in_bri,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsb_pkg::sector_type  out_sector,
   output logic [FRAC_BITS:0]   out_bri,
   output logic [FRAC_BITS:0]   p_val,
   output logic [FRAC_BITS:0]   q_val,
   output logic [FRAC_BITS:0]   t_val
);
   import hsb_pkg::*;

   localparam int F = FRAC_BITS;
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   // stage a
   logic       a_valid_ff, a_valid_in, a_ready;
   sector_type a_sector_ff;
   logic [F:0] a_bri_ff, a_oms_ff, a_omsf_ff, a_oms1f_ff;
   logic [F:0] a_oms_in, a_omsf_in, a_oms1f_in;
   logic [2*F+1:0] sf_prod, s1f_prod;

   // stage b
   logic       b_valid_ff, b_valid_in, b_ready;
   sector_type b_sector_ff;
   logic [F:0] b_bri_ff, p_ff, q_ff, t_ff, p_in, q_in, t_in;
   logic [2*F+1:0] p_prod, q_prod, t_prod;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      sf_prod    = (2*F+2)'(sat) * (2*F+2)'(frac);
      s1f_prod   = (2*F+2)'(sat) * (2*F+2)'(one_minus_frac);
      a_oms_in   = ONE - sat;
      a_omsf_in  = ONE - sf_prod[2*F:F];
      a_oms1f_in = ONE - s1f_prod[2*F:F];
      a_valid_in = a_ready ? in_valid : a_valid_ff;
   end

   always_comb begin
      p_prod     = (2*F+2)'(a_bri_ff) * (2*F+2)'(a_oms_ff);
      q_prod     = (2*F+2)'(a_bri_ff) * (2*F+2)'(a_omsf_ff);
      t_prod     = (2*F+2)'(a_bri_ff) * (2*F+2)'(a_oms1f_ff);
      // products of two values no greater than one stay within f+1 bits
      p_in       = p_prod[2*F:F];
      q_in       = q_prod[2*F:F];
      t_in       = t_prod[2*F:F];
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (a_ready) begin
         a_sector_ff <= in_sector;
         a_bri_ff    <= in_bri;
         a_oms_ff    <= a_oms_in;
         a_omsf_ff   <= a_omsf_in;
         a_oms1f_ff  <= a_oms1f_in;
      end
      if (b_ready) begin
         b_sector_ff <= a_sector_ff;
         b_bri_ff    <= a_bri_ff;
         p_ff        <= p_in;
         q_ff        <= q_in;
         t_ff        <= t_in;
      end
   end

   assign out_valid  = b_valid_ff;
   assign out_sector = b_sector_ff;
   assign out_bri    = b_bri_ff;
   assign p_val      = p_ff;
   assign q_val      = q_ff;
   assign t_val      = t_ff;

endmodule

/* hdl/hsb_out.sv */
// last stage: channel pick per sector and scaling to 8-bit rounded half up
// depends on hsb_pkg
module hsb_out #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsb_pkg::sector_type  sector,
   input  logic [FRAC_BITS:0]   bri,
   input  logic [FRAC_BITS:0]   p_val,
   input  logic [FRAC_BITS:0]   q_val,
   input  logic [FRAC_BITS:0]   t_val,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsb_pkg::hsb_rsp_type out_data
);
   import hsb_pkg::*;

   localparam int F = FRAC_BITS;
   localparam logic [F+8:0] HALF = (F+9)'(1) << (F - 1);

   logic        valid_ff, valid_in;
   hsb_rsp_type data_ff, data_in;
   logic [F:0]  r_sel, g_sel, b_sel;

   function automatic logic [CHAN_W-1:0] to_byte(input logic [F:0] v);
      logic [F+8:0] acc;
      // v*255 as v*256 - v
      acc = ((F+9)'(v) << 8) - (F+9)'(v) + HALF;
      return acc[F+7:F];
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      case (sector)
         SEC_RED_YEL: begin r_sel = bri;   g_sel = t_val; b_sel = p_val; end
         SEC_YEL_GRN: begin r_sel = q_val; g_sel = bri;   b_sel = p_val; end
         SEC_GRN_CYN: begin r_sel = p_val; g_sel = bri;   b_sel = t_val; end
         SEC_CYN_BLU: begin r_sel = p_val; g_sel = q_val; b_sel = bri;   end
         SEC_BLU_MAG: begin r_sel = t_val; g_sel = p_val; b_sel = bri;   end
         default: begin     r_sel = bri;   g_sel = p_val; b_sel = q_val; end
      endcase
      data_in.red_out   = to_byte(r_sel);
      data_in.green_out = to_byte(g_sel);
      data_in.blue_out  = to_byte(b_sel);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hdl/hsb_to_rgb_core.sv */
// top level of the hsb to rgb colour converter
// depends on hsb_pkg, hsb_front, hsb_mul and hsb_out
//
//   channel   ports                          direction   payload
//   request   req_valid req_stall req_data   in          hsb_req_type
//   response  rsp_valid rsp_stall rsp_data   out         hsb_rsp_type
//
// four register stages: clamp and hue times six, s*f products, p/q/t products,
// channel pick and byte scaling; one request per clock while the response is not stalled
// each stage holds its own valid bit and fills bubbles while the response is stalled
// a stall backs up stage by stage, so req_stall rises only once every stage is full
// synchronous reset clears the valid bits only
module hsb_to_rgb_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hsb_pkg::hsb_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsb_pkg::hsb_rsp_type rsp_data
);
   import hsb_pkg::*;

   localparam int F = FRAC_BITS;

   logic       front_ready, front_valid, mul_ready, mul_valid, out_ready_s;
   sector_type front_sector, mul_sector;
   logic [F-1:0] front_frac;
   logic [F:0]   front_omf, front_sat, front_bri;
   logic [F:0]   mul_bri, mul_p, mul_q, mul_t;

   assign req_stall = !front_ready;

   hsb_front #(.FRAC_BITS(F)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (front_ready),
      .in_data        (req_data),
      .out_valid      (front_valid),
      .out_ready      (mul_ready),
      .sector         (front_sector),
      .frac           (front_frac),
      .one_minus_frac (front_omf),
      .sat            (front_sat),
      .bri            (front_bri)
   );

   hsb_mul #(.FRAC_BITS(F)) u_mul (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (front_valid),
      .in_ready       (mul_ready),
      .in_sector      (front_sector),
      .frac           (front_frac),
      .one_minus_frac (front_omf),
      .sat            (front_sat),
      .in_bri         (front_bri),
      .out_valid      (mul_valid),
      .out_ready      (out_ready_s),
      .out_sector     (mul_sector),
      .out_bri        (mul_bri),
      .p_val          (mul_p),
      .q_val          (mul_q),
      .t_val          (mul_t)
   );

   hsb_out #(.FRAC_BITS(F)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (out_ready_s),
      .sector    (mul_sector),
      .bri       (mul_bri),
      .p_val     (mul_p),
      .q_val     (mul_q),
      .t_val     (mul_t),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

/* tb/hsb_checker.sv */
// response checker for the hsb to rgb colour converter: predicts each colour and compares
// depends on hsb_pkg; watches both channels of hsb_to_rgb_core from beside it
`timescale 1ns / 1ps

module hsb_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  hsb_pkg::hsb_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  hsb_pkg::hsb_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending_count
);
   import hsb_pkg::*;

   localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS;

   hsb_rsp_type colour_queue[$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic logic [CHAN_W-1:0] level_to_byte(logic [63:0] v);
      logic [63:0] scaled;
      scaled = (v * 64'd255 + (UNITY >> 1)) >> FRAC_BITS;
      return scaled[CHAN_W-1:0];
   endfunction

   function automatic hsb_rsp_type predict_colour(hsb_req_type r);
      logic [63:0] hue, sat, bri, h6, f, p, q, t, rv, gv, bv;
      sector_type  sec;
      hsb_rsp_type res;
      // only the fraction of a turn matters, so negative hues wrap
      hue = 64'(r.hue_turns) & (UNITY - 64'd1);
      sat = (64'(r.saturation_level) > UNITY) ? UNITY : 64'(r.saturation_level);
      bri = (64'(r.brightness_level) > UNITY) ? UNITY : 64'(r.brightness_level);
      if (sat == 64'd0) begin
         rv = bri;
         gv = bri;
         bv = bri;
      end else begin
         h6  = hue * 64'd6;
         sec = sector_type'(h6[FRAC_BITS+SECTOR_W-1:FRAC_BITS]);
         f   = h6 & (UNITY - 64'd1);
         p   = fx_product(bri, UNITY - sat);
         q   = fx_product(bri, UNITY - fx_product(sat, f));
         t   = fx_product(bri, UNITY - fx_product(sat, UNITY - f));
         case (sec)
            SEC_RED_YEL: begin rv = bri; gv = t;   bv = p;   end
            SEC_YEL_GRN: begin rv = q;   gv = bri; bv = p;   end
            SEC_GRN_CYN: begin rv = p;   gv = bri; bv = t;   end
            SEC_CYN_BLU: begin rv = p;   gv = q;   bv = bri; end
            SEC_BLU_MAG: begin rv = t;   gv = p;   bv = bri; end
            default:     begin rv = bri; gv = p;   bv = q;   end
         endcase
      end
      res.red_out   = level_to_byte(rv);
      res.green_out = level_to_byte(gv);
      res.blue_out  = level_to_byte(bv);
      return res;
   endfunction

   always @(posedge clock) begin
      hsb_rsp_type want;
      if (reset) begin
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (colour_queue.size() == 0) begin
               $display("%0t: response expected none got %h", $time, rsp_data);
               mismatches = mismatches + 1;
            end else begin
               want = colour_queue.pop_front();
               if (rsp_data.red_out !== want.red_out) begin
                  $display("%0t: red expected %0d got %0d", $time, want.red_out,
                           rsp_data.red_out);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.green_out !== want.green_out) begin
                  $display("%0t: green expected %0d got %0d", $time, want.green_out,
                           rsp_data.green_out);
                  mismatches = mismatches + 1;
               end
               if (rsp_data.blue_out !== want.blue_out) begin
                  $display("%0t: blue expected %0d got %0d", $time, want.blue_out,
                           rsp_data.blue_out);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            colour_queue.insert(colour_queue.size(), predict_colour(req_data));
         end
         pending_count <= colour_queue.size();
      end
   end

endmodule

/* tb/tb_top.sv */
// top of the hsb to rgb colour converter testbench: clock, reset, requests and response stalls
// depends on hsb_pkg, hsb_to_rgb_core and hsb_checker
`timescale 1ns / 1ps

module tb_top;
   import hsb_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int UNITY        = 1 << FRAC_BITS;
   localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
   localparam int RANDOM_COUNT = 500;
   localparam int HOLD_CYCLES  = 60;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   hsb_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   hsb_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          hold_asked;

   hsb_to_rgb_core #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hsb_checker #(.FRAC_BITS(FRAC_BITS)) colour_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic hsb_req_type make_request(int hue, int sat, int bri);
      hsb_req_type r;
      r.hue_turns        = HUE_W'(hue);
      r.saturation_level = LEVEL_W'(sat);
      r.brightness_level = LEVEL_W'(bri);
      return r;
   endfunction

   function automatic int random_level();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return UNITY;
         2:       return $urandom_range(UNITY + 1, LEVEL_MAX);
         3:       return $urandom_range(0, 255);
         default: return $urandom_range(0, UNITY);
      endcase
   endfunction

   function automatic hsb_req_type random_request();
      int hue;
      // some hues sit on or just beside a sector boundary, the rest anywhere in range
      if ($urandom_range(0, 4) == 0) begin
         hue = ($urandom_range(0, 255) << FRAC_BITS) + ($urandom_range(0, 6) * UNITY) / 6
               + $urandom_range(0, 4) - 2;
      end else begin
         hue = $urandom;
      end
      return make_request(hue, random_level(), random_level());
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(hsb_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // response side stall pattern, with a long hold-off whenever one is asked for
   initial begin
      stall_mode_type mode;
      int mode_left;
      int hold_left;
      int holds_done;
      mode       = STALL_NONE;
      mode_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done != hold_asked) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_done + 1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 60);
            end
            mode_left = mode_left - 1;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      int sent;
      int burst;
      int gap;
      bit squeezed;
      bit drained;
      sent     = 0;
      burst    = 0;
      gap      = 0;
      squeezed = 1'b0;
      drained  = 1'b0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      hold_asked <= 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // zero saturation, out of range levels, sector boundaries and wrapping hues
      send_request(make_request(0, 0, 0));
      send_request(make_request(0, 0, UNITY));
      send_request(make_request(0, 0, UNITY / 2));
      send_request(make_request(0, 0, LEVEL_MAX));
      send_request(make_request(0, UNITY, UNITY));
      send_request(make_request(10923, UNITY, UNITY));
      send_request(make_request(21846, UNITY, UNITY));
      send_request(make_request(32768, UNITY, UNITY));
      send_request(make_request(43691, UNITY, UNITY));
      send_request(make_request(54614, UNITY, UNITY));
      send_request(make_request(10922, UNITY, UNITY));
      send_request(make_request(65535, UNITY, UNITY));
      send_request(make_request(-1, UNITY, UNITY));
      send_request(make_request(-8388608, 40000, 50000));
      send_request(make_request(8388607, 40000, 50000));
      send_request(make_request('h123456, LEVEL_MAX, LEVEL_MAX));
      send_request(make_request(-10923, UNITY / 2, UNITY));
      send_request(make_request(5461, 1, UNITY));
      send_request(make_request(5461, UNITY / 2, 1));
      send_request(make_request(32768, UNITY - 1, UNITY - 1));
      send_request(make_request(49152, 98304, 20000));
      wait_idle();

      while (sent < RANDOM_COUNT) begin
         if (!squeezed && sent >= 150) begin
            // response held off while requests keep coming, so the pipe fills
            hold_asked <= hold_asked + 1;
            repeat (32) send_request(random_request());
            sent     = sent + 32;
            squeezed = 1'b1;
         end
         if (!drained && sent >= 300) begin
            wait_idle();
            drained = 1'b1;
         end
         burst = $urandom_range(1, 24);
         repeat (burst) send_request(random_request());
         sent = sent + burst;
         gap  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
